// ===== sv/fed_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fed_pkg
// Types, constants and fixed-point helpers for the feedback echo delay unit.
// ----------------------------------------------------------------------------
package fed_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_BITS   = 16;
  localparam int GAIN_BITS   = 17;
  localparam int CFG_AW      = 2;
  localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int RND_BITS    = PROD_BITS - 15;
  localparam int WIDE_BITS   = RND_BITS + 1;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(65536);
  localparam logic [GAIN_BITS-1:0] GAIN_HALF = GAIN_BITS'(32768);
  localparam logic [ADDR_BITS-1:0] DELAY_RESET = ADDR_BITS'(24000);

  localparam logic [CFG_AW-1:0] REG_DELAY    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FEEDBACK = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MIX      = 2'd2;

  localparam logic signed [WIDE_BITS-1:0] SAT_HI =
      (WIDE_BITS'(1) <<< (SAMPLE_BITS - 1)) - WIDE_BITS'(1);
  localparam logic signed [WIDE_BITS-1:0] SAT_LO = -SAT_HI - WIDE_BITS'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;

  // Q.16 to integer, nearest with ties toward plus infinity.
  function automatic logic signed [RND_BITS-1:0] q16_round(input prod_t v);
    logic signed [PROD_BITS:0] t;
    t = {v[PROD_BITS-1], v} + (PROD_BITS+1)'(GAIN_HALF);
    return t[PROD_BITS:16];
  endfunction

  function automatic sample_t sat_sample(input logic signed [WIDE_BITS-1:0] v);
    sample_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  function automatic gain_t clamp_gain(input gain_t g);
    return (g > GAIN_ONE) ? GAIN_ONE : g;
  endfunction

endpackage
`default_nettype wire

// ===== sv/feedback_echo_delay_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// feedback_echo_delay_unit
// Echo with feedback over a 64K-sample circular delay memory.
// ----------------------------------------------------------------------------
// One 24-bit sample in gives one mixed sample out, registered through the
// pipeline stages and the output register. With a delay of three samples
// or more a new item is taken every cycle while the output is not stalled;
// the delay memory has one read and one write port, and an item whose read
// address is still to be written by an item in flight waits for that
// write, so a delay of one or two samples stalls the input until then. No
// clearing pass follows reset: the memory fills in address order, and until
// the write position first wraps, any entry at or above it reads as zero.
module feedback_echo_delay_unit (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [fed_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire [fed_pkg::GAIN_BITS-1:0] cfg_data,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [23:0]                   s_tdata,   // [23:0] sample_in
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [23:0]                  m_tdata    // [23:0] sample_out
);
  import fed_pkg::*;

  addr_t   delay_samples;
  gain_t   feedback_gain;
  gain_t   mix_level;

  addr_t   wp;
  logic    wrapped;

  sample_t echo_store [2**ADDR_BITS];
  sample_t rd_data;

  logic    s1_valid;
  addr_t   s1_wp;
  sample_t s1_dry;
  logic    s1_rd_ok;

  logic    s2_valid;
  addr_t   s2_wp;
  sample_t s2_dry;
  prod_t   s2_fb_prod;
  prod_t   s2_wet_mix;
  prod_t   s2_dry_mix;

  addr_t   delay_eff;
  addr_t   rd_addr;
  logic    hazard;
  logic    en;
  logic    accept;
  sample_t wet;
  gain_t   fb_eff;
  gain_t   mx_eff;
  gain_t   dry_gain;
  sample_t stored;
  sample_t mixed;
  prod_t   mix_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= DELAY_RESET;
      feedback_gain <= GAIN_HALF;
      mix_level     <= GAIN_HALF;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DELAY:    delay_samples <= cfg_data[ADDR_BITS-1:0];
        REG_FEEDBACK: feedback_gain <= cfg_data;
        REG_MIX:      mix_level     <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign delay_eff = (delay_samples == '0) ? addr_t'(1) : delay_samples;
  assign rd_addr   = wp - delay_eff;
  // An entry still owed by an item in flight must not be read yet.
  assign hazard    = (s1_valid && (s1_wp == rd_addr)) ||
                     (s2_valid && (s2_wp == rd_addr));
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en && !hazard;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (accept) begin
      wp <= wp + addr_t'(1);
      if (wp == '1) begin
        wrapped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= echo_store[rd_addr];
      if (s2_valid) begin
        echo_store[s2_wp] <= stored;
      end
    end
  end

  // Stage 1: delay memory data arrives, gain products are formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_wp    <= wp;
      s1_dry   <= sample_t'(s_tdata);
      s1_rd_ok <= wrapped || (rd_addr < wp);
    end
  end

  assign fb_eff   = clamp_gain(feedback_gain);
  assign mx_eff   = clamp_gain(mix_level);
  assign dry_gain = GAIN_ONE - mx_eff;
  assign wet      = s1_rd_ok ? rd_data : '0;

  // Stage 2: round, saturate, write back and mix.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_wp      <= s1_wp;
      s2_dry     <= s1_dry;
      s2_fb_prod <= prod_t'(wet) * prod_t'($signed({1'b0, fb_eff}));
      s2_wet_mix <= prod_t'(wet) * prod_t'($signed({1'b0, mx_eff}));
      s2_dry_mix <= prod_t'(s1_dry) * prod_t'($signed({1'b0, dry_gain}));
    end
  end

  assign stored  = sat_sample(WIDE_BITS'(s2_dry) + WIDE_BITS'(q16_round(s2_fb_prod)));
  assign mix_sum = s2_wet_mix + s2_dry_mix;
  assign mixed   = sat_sample(WIDE_BITS'(q16_round(mix_sum)));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= mixed;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fed_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fed_checker
// Port-level checks for the feedback echo delay unit.
// ----------------------------------------------------------------------------
module fed_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [23:0] m_tdata
);

  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // Items taken in whose result has not yet been taken out.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown straight after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
      out_acc |-> (pending != 3'd0))
    else $error("result delivered with no item outstanding");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
      pending <= 3'd3)
    else $error("more items in flight than the pipeline holds");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind feedback_echo_delay_unit fed_checker u_fed_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/feedback_echo_delay_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_echo_delay_unit_tb
// Self-checking bench for the feedback echo delay unit. An item-level model
// of the delay line predicts every mixed sample from the accepted dry
// samples. Directed items cover the sample extremes and the register corner
// cases. Random phases follow under changing delay, feedback and mix
// settings, with random stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module feedback_echo_delay_unit_tb;
  import fed_pkg::*;

  localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;
  localparam longint UNITY = 65536;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 217;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [GAIN_BITS-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;

  // Model state: the delay line and the register copies.
  sample_t echo_line [65536];
  addr_t write_pos;
  logic [15:0] delay_len;
  gain_t fb_gain;
  gain_t mix_gain;

  sample_t dry_pending[$];
  sample_t mixed_due[$];
  logic item_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int errors = 0;
  int cycles = 0;

  feedback_echo_delay_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [23:0] sample_in
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [23:0] sample_out
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint q16_nearest(input longint v);
    // Arithmetic shift gives the floor, so ties go towards plus infinity.
    return (v + 32768) >>> 16;
  endfunction

  function automatic sample_t clip(input longint v);
    if (v > 64'sd8388607) begin
      return sample_t'(24'h7FFFFF);
    end else if (v < -64'sd8388608) begin
      return sample_t'(24'h800000);
    end
    return sample_t'(v);
  endfunction

  // Advances the delay line by one dry sample and returns the mixed sample.
  function automatic sample_t echo_mix(input sample_t dry);
    logic [15:0] d;
    addr_t rd_pos;
    sample_t wet;
    longint fb;
    longint mx;
    d = (delay_len == 16'd0) ? 16'd1 : delay_len;
    rd_pos = write_pos - d;
    wet = echo_line[rd_pos];
    fb = (longint'(fb_gain) > UNITY) ? UNITY : longint'(fb_gain);
    mx = (longint'(mix_gain) > UNITY) ? UNITY : longint'(mix_gain);
    echo_line[write_pos] = clip(longint'(dry) + q16_nearest(longint'(wet) * fb));
    write_pos = write_pos + addr_t'(1);
    return clip(q16_nearest(longint'(wet) * mx + longint'(dry) * (UNITY - mx)));
  endfunction

  // Driver: keeps an item on offer until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || item_taken) begin
      if (dry_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata <= dry_pending.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output ready, with a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done = holds_done + 1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: checks each output item, then predicts for each input item.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (mixed_due.size() == 0) begin
        $error("sample_out: no item expected, got %0d", $signed(m_tdata));
        errors++;
      end else begin
        sample_t want;
        want = mixed_due.pop_front();
        if (sample_t'(m_tdata) !== want) begin
          $error("sample_out: expected %0d, got %0d", want, $signed(m_tdata));
          errors++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      mixed_due.push_back(echo_mix(sample_t'(s_tdata)));
      item_taken <= 1'b1;
    end else begin
      item_taken <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic reg_write(input logic [CFG_AW-1:0] idx, input gain_t val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_DELAY:    delay_len = val[15:0];
      REG_FEEDBACK: fb_gain = val;
      REG_MIX:      mix_gain = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (dry_pending.size() != 0 || s_tvalid || mixed_due.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  function automatic gain_t pick_gain();
    case ($urandom_range(7))
      0: return '0;
      1: return GAIN_ONE;
      2: return gain_t'($urandom_range(131071, 65537));
      default: return gain_t'($urandom_range(65536));
    endcase
  endfunction

  function automatic gain_t pick_delay();
    case ($urandom_range(9))
      0: return '0;
      1: return gain_t'(1);
      2: return gain_t'(2);
      3: return gain_t'(65535);
      4: return gain_t'($urandom_range(131071));
      default: return gain_t'($urandom_range(48, 3));
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(3))
      0: return sample_t'($urandom);
      1: return $urandom_range(1) ? sample_t'(32'h7FFFFF - $urandom_range(15))
                                  : sample_t'(32'h800000 + $urandom_range(15));
      2: return sample_t'(int'($urandom_range(2000)) - 1000);
      default: return sample_t'({$urandom_range(1), 1'b1, 22'($urandom)});
    endcase
  endfunction

  initial begin
    int ph;
    int n;
    foreach (echo_line[i]) echo_line[i] = '0;
    write_pos = '0;
    delay_len = DELAY_RESET;
    fb_gain = GAIN_HALF;
    mix_gain = GAIN_HALF;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: the echo reads only entries not yet written, which read as zero.
    dry_pending = '{24'sh7FFFFF, -24'sh800000, 24'sh000000, -24'sh000001};
    drain();

    // Zero delay acts as one; an over-unity feedback gain clips; the stored sum saturates.
    reg_write(REG_DELAY, '0);
    reg_write(REG_FEEDBACK, 17'h1FFFF);
    reg_write(REG_MIX, GAIN_ONE);
    dry_pending = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                    -24'sh800000, -24'sh800000, -24'sh800000, 24'sh003039};
    drain();

    // Delay with its top data bit set is cut to 16 bits; a write to the
    // spare index must change nothing; no feedback, dry only.
    reg_write(REG_DELAY, 17'h10002);
    reg_write(REG_FEEDBACK, '0);
    reg_write(REG_MIX, '0);
    reg_write(REG_UNUSED, 17'h00005);
    dry_pending = '{24'sh000001, -24'sh000001, 24'sh007FFF, -24'sh008000, 24'sh000064};
    drain();

    // Longest delay, gains just below unity and just above zero.
    reg_write(REG_DELAY, gain_t'(65535));
    reg_write(REG_FEEDBACK, gain_t'(65535));
    reg_write(REG_MIX, gain_t'(1));
    dry_pending = '{24'sh400000, -24'sh400001, 24'sh123456};
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 47;
      end else if (ph < 4) begin
        send_idle_pct = 47;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      reg_write(REG_DELAY, pick_delay());
      reg_write(REG_FEEDBACK, pick_gain());
      reg_write(REG_MIX, pick_gain());
      for (n = 0; n < PHASE_ITEMS; n++) dry_pending.push_back(pick_sample());
      // Hold the output back while the sender keeps offering, to fill the block.
      if (ph == 4) hold_requests++;
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
